// File: rtl/pma_pkg.sv
// ----------------------------------------------------------------------------
// Power monitor accumulator package
// Shared widths, constants, state and step codes, and the control struct
// that passes between the sequencer and the bit-serial arithmetic unit.
// ----------------------------------------------------------------------------
package pma_pkg;

    // Width of the shared serial datapath (largest product and dividend).
    localparam int SER_W    = 51;
    // Multiplier operand width; one bit is consumed per cycle.
    localparam int MUL_BITS = 18;
    // Iteration counter width, large enough to hold SER_W.
    localparam int CNT_W    = 6;

    // Default width of the elapsed-time field.
    localparam int TIME_WIDTH_DEF = 24;

    // Shunt resistance in milliohm, and the derived shunt current scaling.
    localparam int SHUNT_MILLIOHM = 10;
    localparam int QMA_SHIFT_LO   = $clog2(40 / SHUNT_MILLIOHM);

    // Fixed divisors and scale factors.
    localparam logic [SER_W-1:0] MON_DIV     = SER_W'(16000);
    localparam logic [SER_W-1:0] MILLI_DIV   = SER_W'(1000);
    localparam logic [SER_W-1:0] QMA_US_MAH  = SER_W'(64'd14400000000);
    localparam logic [SER_W-1:0] US_PER_HOUR = SER_W'(64'd3600000000);

    // Register reset values.
    localparam logic        RST_VARIANT   = 1'b0;
    localparam logic [15:0] RST_CAPACITY  = 16'd2000;
    localparam logic [21:0] RST_THRESHOLD = 22'd20000;
    localparam logic [15:0] RST_CAP_HOURS = 16'd10000;

    // Configuration register indexes.
    localparam logic [1:0] CFG_VARIANT   = 2'd0;
    localparam logic [1:0] CFG_CAPACITY  = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;
    localparam logic [1:0] CFG_CAP_HOURS = 2'd3;

    // Charger status bits.
    localparam int STAT_CHARGING = 5;
    localparam int STAT_OUT_ON   = 3;

    // Current clear codes.
    localparam logic signed [17:0] QMA_MIN = -18'sd131072;
    localparam logic signed [17:0] QMA_MAX = 18'sd131071;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_WAIT,
        S_CHG,
        S_RUN,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        ST_MON_MUL,
        ST_MON_DIV,
        ST_SYS_MUL,
        ST_SYS_DIV,
        ST_BAT_MUL,
        ST_BAT_DIV,
        ST_CAP_MUL,
        ST_CHG_MUL,
        ST_CHG_DIV,
        ST_RUN_MUL
    } t_step;

    typedef enum logic {
        SER_MUL,
        SER_DIV
    } t_ser_op;

    typedef struct packed {
        logic    start;
        t_ser_op op;
    } t_ser_ctl;

endpackage

// File: rtl/pma_serial.sv
// ----------------------------------------------------------------------------
// Bit-serial arithmetic unit
// Unsigned shift-add multiply (one multiplier bit per cycle) and restoring
// divide (one quotient bit per cycle) over a shared set of shift registers.
// ----------------------------------------------------------------------------
module pma_serial (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pma_pkg::t_ser_ctl          i_ctl,
    input  logic [pma_pkg::SER_W-1:0]  i_opa,
    input  logic [pma_pkg::SER_W-1:0]  i_opb,
    output logic                       o_done,
    output logic [pma_pkg::SER_W-1:0]  o_acc,
    output logic [pma_pkg::SER_W-1:0]  o_quo
);

    logic                      r_busy, n_busy;
    logic                      r_done, n_done;
    pma_pkg::t_ser_op          r_op, n_op;
    logic [pma_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [pma_pkg::SER_W-1:0] r_acc, n_acc;
    logic [pma_pkg::SER_W-1:0] r_opa, n_opa;
    logic [pma_pkg::SER_W-1:0] r_opb, n_opb;
    logic [pma_pkg::SER_W-1:0] trial;
    logic                      fits;

    // Restoring divide step: shift in the next dividend bit and try a subtract.
    assign trial = {r_acc[pma_pkg::SER_W-2:0], r_opb[pma_pkg::SER_W-1]};
    assign fits  = (trial >= r_opa);

    // Next-value logic for one iteration.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_opa  = r_opa;
        n_opb  = r_opb;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_op   = i_ctl.op;
            n_acc  = '0;
            n_opa  = i_opa;
            n_opb  = i_opb;
            n_cnt  = (i_ctl.op == pma_pkg::SER_MUL) ? pma_pkg::CNT_W'(pma_pkg::MUL_BITS)
                                                     : pma_pkg::CNT_W'(pma_pkg::SER_W);
        end else if (r_busy) begin
            unique case (r_op)
                pma_pkg::SER_MUL: begin
                    n_acc = r_opb[0] ? r_acc + r_opa : r_acc;
                    n_opa = {r_opa[pma_pkg::SER_W-2:0], 1'b0};
                    n_opb = {1'b0, r_opb[pma_pkg::SER_W-1:1]};
                end
                pma_pkg::SER_DIV: begin
                    n_acc = fits ? trial - r_opa : trial;
                    n_opb = {r_opb[pma_pkg::SER_W-2:0], fits};
                end
            endcase
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == pma_pkg::CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Datapath shift registers.
    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_opa <= n_opa;
        r_opb <= n_opb;
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;
    assign o_quo  = r_opb;

    // A new operation is only started while the unit is free.
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> !r_busy)
        else $error("serial unit started while busy");

    // The done pulse closes the operation.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("done raised while still busy");

    // The partial remainder stays below a nonzero divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_op == pma_pkg::SER_DIV && r_opa != '0) |-> (r_acc < r_opa))
        else $error("partial remainder not below divisor");

endmodule

// File: rtl/power_monitor_accumulator.sv
// Ten serial multiply and divide steps run on one shared bit-serial unit, and
// o_stall holds off the next item until they and the output hand-off are done.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low) clears the peak, minimum, charge, cycle and
// runtime state and restores the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// Power monitor accumulator
// Scales current-monitor readings, picks reported voltage and power, tracks
// current extremes, counts charge into battery cycles and meters motor runtime.
// ----------------------------------------------------------------------------
module power_monitor_accumulator #(
    parameter int TIME_WIDTH = pma_pkg::TIME_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Configuration port
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_index,
    input  logic [21:0]             i_cfg_data,
    // Input channel
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_mode,
    input  logic [TIME_WIDTH-1:0]   i_elapsed_us,
    input  logic [15:0]             i_bus_raw,
    input  logic signed [15:0]      i_shunt_raw,
    input  logic                    i_monitor_ok,
    input  logic [7:0]              i_charger_status,
    input  logic [15:0]             i_battery_mv,
    input  logic [15:0]             i_system_mv,
    input  logic signed [15:0]      i_battery_ma,
    input  logic signed [15:0]      i_system_ma,
    input  logic [15:0]             i_system_power_raw,
    input  logic                    i_charger_ok,
    // Output channel
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [16:0]             o_report_bus_mv,
    output logic signed [17:0]      o_current_qma,
    output logic signed [22:0]      o_output_mw,
    output logic [21:0]             o_input_mw,
    output logic signed [17:0]      o_current_peak,
    output logic signed [17:0]      o_current_low,
    output logic [49:0]             o_charge_residue,
    output logic [31:0]             o_cycle_count,
    output logic [47:0]             o_runtime_us,
    output logic                    o_save_request
);

    localparam int SW = pma_pkg::SER_W;

    // Sequencer state
    pma_pkg::t_state r_state, n_state;
    pma_pkg::t_step  r_step, n_step;

    // Configuration registers
    logic        r_variant;
    logic [15:0] r_capacity;
    logic [21:0] r_threshold;
    logic [15:0] r_cap_hours;

    // Persistent state
    logic signed [17:0] r_peak, r_low;
    logic [49:0]        r_charge;
    logic [31:0]        r_cycles;
    logic [47:0]        r_runtime;

    // Captured item
    logic                  r_mode;
    logic [TIME_WIDTH-1:0] r_dt;
    logic [15:0]           r_bus;
    logic signed [15:0]    r_shunt;
    logic                  r_mon_ok;
    logic [7:0]            r_status;
    logic [15:0]           r_bat_mv, r_sys_mv;
    logic signed [15:0]    r_bat_ma, r_sys_ma;
    logic [15:0]           r_sys_pw;
    logic                  r_chg_ok;

    // Intermediate results
    logic [21:0]        r_mon_mag, r_sys_mag, r_bat_mag;
    logic [49:0]        r_cap_units;
    logic [SW-1:0]      r_div_quo;
    logic [49:0]        r_div_rem;
    logic [47:0]        r_cap_us;
    logic signed [22:0] r_out_mw;
    logic [21:0]        r_in_mw;
    logic               r_save;

    // Output register
    logic               r_out_valid;
    logic [16:0]        r_o_bus_mv;
    logic signed [17:0] r_o_qma, r_o_peak, r_o_low;
    logic signed [22:0] r_o_out_mw;
    logic [21:0]        r_o_in_mw;
    logic [49:0]        r_o_charge;
    logic [31:0]        r_o_cycles;
    logic [47:0]        r_o_runtime;
    logic               r_o_save;

    // Serial unit interface
    pma_pkg::t_ser_ctl ser_ctl;
    logic [SW-1:0]     ser_opa, ser_opb, ser_acc, ser_quo;
    logic              ser_done;

    // Combinational item values
    logic signed [17:0] qma;
    logic [17:0]        qma_mag;
    logic               qma_pos;
    logic [18:0]        bus_q5, bus_qmv;
    logic [16:0]        report_mv;
    logic signed [16:0] sys_ma_x, bat_ma_x;
    logic [16:0]        sys_ma_mag, bat_ma_mag;
    logic [19:0]        pw10;
    logic signed [22:0] mon_mw, out_mw;
    logic [21:0]        in_mw;
    logic               out_free;
    logic               chg_en;
    logic [32:0]        cyc_sum;
    logic               cyc_sat;
    logic [48:0]        run_sum;
    logic               run_en;

    // Shunt current and bus voltage scaling.
    assign qma = !r_mon_ok ? '0 :
                 r_variant ? 18'(r_shunt) : (18'(r_shunt) <<< pma_pkg::QMA_SHIFT_LO);
    assign qma_mag = qma[17] ? 18'(-qma) : 18'(qma);
    assign qma_pos = !qma[17] && (qma != '0);
    assign bus_q5  = {1'b0, r_bus, 2'b00} + {3'b000, r_bus};
    assign bus_qmv = r_variant ? bus_q5 : {2'b00, r_bus[15:3], 4'b0000};

    // Reported bus voltage: monitor first, then charger system voltage.
    assign report_mv = r_mon_ok ? bus_qmv[18:2] :
                       r_chg_ok ? {1'b0, r_sys_mv} : '0;

    // Current magnitudes for the charger products.
    assign sys_ma_x   = 17'(r_sys_ma);
    assign bat_ma_x   = 17'(r_bat_ma);
    assign sys_ma_mag = sys_ma_x[16] ? 17'(-sys_ma_x) : 17'(sys_ma_x);
    assign bat_ma_mag = bat_ma_x[16] ? 17'(-bat_ma_x) : 17'(bat_ma_x);

    // Output and input power selection.
    assign pw10   = {1'b0, r_sys_pw, 3'b000} + {3'b000, r_sys_pw, 1'b0};
    assign mon_mw = qma[17] ? -$signed({1'b0, r_mon_mag}) : $signed({1'b0, r_mon_mag});
    always_comb begin
        if (!r_chg_ok) begin
            out_mw = mon_mw;
        end else if (!r_status[pma_pkg::STAT_OUT_ON]) begin
            out_mw = '0;
        end else if (r_sys_pw != '0) begin
            out_mw = 23'(pw10);
        end else begin
            out_mw = $signed({1'b0, r_sys_mag});
        end
    end
    assign in_mw = (r_chg_ok && r_status[pma_pkg::STAT_CHARGING]) ? r_bat_mag : '0;

    // Charge and cycle arithmetic.
    assign chg_en  = !r_mode && qma_pos && (r_capacity != '0);
    assign cyc_sum = {1'b0, r_cycles} + {1'b0, r_div_quo[31:0]};
    assign cyc_sat = (|r_div_quo[SW-1:32]) || (cyc_sum >= 33'h0_FFFF_FFFF);

    // Runtime arithmetic.
    assign run_sum = {1'b0, r_runtime} + 49'(r_dt);
    assign run_en  = !r_mode && ($signed(r_out_mw) >= $signed({1'b0, r_threshold}))
                     && (r_runtime < r_cap_us);

    assign out_free = !r_out_valid || !i_stall;

    // Operands for each serial step.
    always_comb begin
        ser_opa = '0;
        ser_opb = '0;
        unique case (r_step)
            pma_pkg::ST_MON_MUL: begin
                ser_opa = SW'(bus_qmv);
                ser_opb = SW'(qma_mag);
            end
            pma_pkg::ST_SYS_MUL: begin
                ser_opa = SW'(r_sys_mv);
                ser_opb = SW'(sys_ma_mag);
            end
            pma_pkg::ST_BAT_MUL: begin
                ser_opa = SW'(r_bat_mv);
                ser_opb = SW'(bat_ma_mag);
            end
            pma_pkg::ST_MON_DIV: begin
                ser_opa = pma_pkg::MON_DIV;
                ser_opb = ser_acc;
            end
            pma_pkg::ST_SYS_DIV, pma_pkg::ST_BAT_DIV: begin
                ser_opa = pma_pkg::MILLI_DIV;
                ser_opb = ser_acc;
            end
            pma_pkg::ST_CAP_MUL: begin
                ser_opa = pma_pkg::QMA_US_MAH;
                ser_opb = SW'(r_capacity);
            end
            pma_pkg::ST_CHG_MUL: begin
                ser_opa = SW'(r_dt);
                ser_opb = SW'(qma_mag);
            end
            pma_pkg::ST_CHG_DIV: begin
                ser_opa = SW'(r_cap_units);
                ser_opb = {1'b0, r_charge} + ser_acc;
            end
            pma_pkg::ST_RUN_MUL: begin
                ser_opa = pma_pkg::US_PER_HOUR;
                ser_opb = SW'(r_cap_hours);
            end
            default: begin
                ser_opa = '0;
                ser_opb = '0;
            end
        endcase
    end

    // Sequencer next state and serial unit control.
    always_comb begin
        n_state       = r_state;
        n_step        = r_step;
        ser_ctl.start = 1'b0;
        ser_ctl.op    = pma_pkg::SER_MUL;
        unique case (r_state)
            pma_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = pma_pkg::S_LOAD;
                    n_step  = pma_pkg::ST_MON_MUL;
                end
            end
            pma_pkg::S_LOAD: begin
                ser_ctl.start = 1'b1;
                if (r_step == pma_pkg::ST_MON_DIV || r_step == pma_pkg::ST_SYS_DIV ||
                    r_step == pma_pkg::ST_BAT_DIV || r_step == pma_pkg::ST_CHG_DIV) begin
                    ser_ctl.op = pma_pkg::SER_DIV;
                end
                n_state = pma_pkg::S_WAIT;
            end
            pma_pkg::S_WAIT: begin
                if (ser_done) begin
                    if (r_step == pma_pkg::ST_RUN_MUL) begin
                        n_state = pma_pkg::S_CHG;
                    end else begin
                        n_state = pma_pkg::S_LOAD;
                        n_step  = pma_pkg::t_step'(r_step + 4'd1);
                    end
                end
            end
            pma_pkg::S_CHG: begin
                n_state = pma_pkg::S_RUN;
            end
            pma_pkg::S_RUN: begin
                n_state = pma_pkg::S_OUT;
            end
            pma_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = pma_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pma_pkg::S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != pma_pkg::S_IDLE);

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pma_pkg::S_IDLE;
            r_step  <= pma_pkg::ST_MON_MUL;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    pma_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ser_ctl),
        .i_opa   (ser_opa),
        .i_opb   (ser_opb),
        .o_done  (ser_done),
        .o_acc   (ser_acc),
        .o_quo   (ser_quo)
    );

    // Configuration, persistent state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant   <= pma_pkg::RST_VARIANT;
            r_capacity  <= pma_pkg::RST_CAPACITY;
            r_threshold <= pma_pkg::RST_THRESHOLD;
            r_cap_hours <= pma_pkg::RST_CAP_HOURS;
            r_peak      <= '0;
            r_low       <= '0;
            r_charge    <= '0;
            r_cycles    <= '0;
            r_runtime   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pma_pkg::CFG_VARIANT:   r_variant   <= i_cfg_data[0];
                    pma_pkg::CFG_CAPACITY:  r_capacity  <= i_cfg_data[15:0];
                    pma_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data;
                    pma_pkg::CFG_CAP_HOURS: r_cap_hours <= i_cfg_data[15:0];
                endcase
            end
            // Current extremes, charge and cycle count.
            if (r_state == pma_pkg::S_CHG) begin
                if (r_mode) begin
                    r_peak <= pma_pkg::QMA_MIN;
                    r_low  <= pma_pkg::QMA_MAX;
                end else begin
                    if (qma > r_peak) r_peak <= qma;
                    if (qma < r_low)  r_low  <= qma;
                end
                if (chg_en) begin
                    r_charge <= r_div_rem;
                    if (r_div_quo != '0) begin
                        r_cycles <= cyc_sat ? '1 : cyc_sum[31:0];
                    end
                end
            end
            // Motor runtime, clamped to the cap.
            if (r_state == pma_pkg::S_RUN && run_en) begin
                r_runtime <= (run_sum > {1'b0, r_cap_us}) ? r_cap_us : run_sum[47:0];
            end
            // Output register handshake.
            if (r_state == pma_pkg::S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item capture, intermediate results and output payload.
    always_ff @(posedge i_clk) begin
        if (r_state == pma_pkg::S_IDLE && i_valid) begin
            r_mode   <= i_mode;
            r_dt     <= i_elapsed_us;
            r_bus    <= i_bus_raw;
            r_shunt  <= i_shunt_raw;
            r_mon_ok <= i_monitor_ok;
            r_status <= i_charger_status;
            r_bat_mv <= i_battery_mv;
            r_sys_mv <= i_system_mv;
            r_bat_ma <= i_battery_ma;
            r_sys_ma <= i_system_ma;
            r_sys_pw <= i_system_power_raw;
            r_chg_ok <= i_charger_ok;
        end
        if (r_state == pma_pkg::S_WAIT && ser_done) begin
            unique case (r_step)
                pma_pkg::ST_MON_DIV: r_mon_mag   <= ser_quo[21:0];
                pma_pkg::ST_SYS_DIV: r_sys_mag   <= ser_quo[21:0];
                pma_pkg::ST_BAT_DIV: r_bat_mag   <= ser_quo[21:0];
                pma_pkg::ST_CAP_MUL: r_cap_units <= ser_acc[49:0];
                pma_pkg::ST_CHG_DIV: begin
                    r_div_quo <= ser_quo;
                    r_div_rem <= ser_acc[49:0];
                end
                pma_pkg::ST_RUN_MUL: r_cap_us    <= ser_acc[47:0];
                default: ;
            endcase
        end
        // Power selection and the cycle part of the save flag.
        if (r_state == pma_pkg::S_CHG) begin
            r_out_mw <= out_mw;
            r_in_mw  <= in_mw;
            r_save   <= chg_en && (r_div_quo != '0);
        end
        if (r_state == pma_pkg::S_RUN && run_en) begin
            r_save <= 1'b1;
        end
        if (r_state == pma_pkg::S_OUT && out_free) begin
            r_o_bus_mv  <= report_mv;
            r_o_qma     <= qma;
            r_o_out_mw  <= r_out_mw;
            r_o_in_mw   <= r_in_mw;
            r_o_peak    <= r_peak;
            r_o_low     <= r_low;
            r_o_charge  <= r_charge;
            r_o_cycles  <= r_cycles;
            r_o_runtime <= r_runtime;
            r_o_save    <= r_save;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_report_bus_mv  = r_o_bus_mv;
    assign o_current_qma    = r_o_qma;
    assign o_output_mw      = r_o_out_mw;
    assign o_input_mw       = r_o_in_mw;
    assign o_current_peak   = r_o_peak;
    assign o_current_low    = r_o_low;
    assign o_charge_residue = r_o_charge;
    assign o_cycle_count    = r_o_cycles;
    assign o_runtime_us     = r_o_runtime;
    assign o_save_request   = r_o_save;

    // An accepted transfer always starts the first serial step.
    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == pma_pkg::S_LOAD &&
                                   r_step == pma_pkg::ST_MON_MUL))
        else $error("accepted item did not start the sequence");

    // The cycle count never decreases outside reset.
    a_cycles_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_cycles >= $past(r_cycles)))
        else $error("cycle count decreased");

    // The runtime never decreases outside reset.
    a_runtime_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_runtime >= $past(r_runtime)))
        else $error("runtime decreased");

endmodule
